/* rtl/core/svpu_pkg.sv */
// Shared types and constants for the vector permute unit.
// No dependencies; used by svpu_permute and simd_vector_permute_unit_top.
package svpu_pkg;

    localparam int VecW  = 128;
    localparam int HalfW = 64;

    // operation codes
    localparam logic [2:0] OP_TRN1 = 3'd0;
    localparam logic [2:0] OP_TRN2 = 3'd1;
    localparam logic [2:0] OP_UZP1 = 3'd2;
    localparam logic [2:0] OP_UZP2 = 3'd3;
    localparam logic [2:0] OP_ZIP1 = 3'd4;
    localparam logic [2:0] OP_ZIP2 = 3'd5;

    // element size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    typedef struct packed {
        logic [2:0]       opcode;
        logic             full_width;
        logic [1:0]       elem_size;
        logic [HalfW-1:0] first_low;
        logic [HalfW-1:0] first_high;
        logic [HalfW-1:0] second_low;
        logic [HalfW-1:0] second_high;
    } perm_item_t;

    typedef struct packed {
        logic             reserved_encoding;
        logic [HalfW-1:0] result_low;
        logic [HalfW-1:0] result_high;
    } perm_result_t;

endpackage

/* rtl/core/svpu_permute.sv */
// Combinational TRN/UZP/ZIP permute network, one copy per element size.
// Depends on svpu_pkg for item/result types and operation codes.
module svpu_permute (
    input  svpu_pkg::perm_item_t   item,
    output svpu_pkg::perm_result_t result
);

    logic [3:0][svpu_pkg::VecW-1:0] by_size;

    for (genvar g = 0; g < 4; g++) begin : g_size
        localparam int EW = 8 << g;
        localparam int NE = svpu_pkg::VecW / EW;
        localparam int HE = NE / 2;
        localparam int QE = NE / 4;

        logic [NE-1:0][EW-1:0]   nv;
        logic [NE-1:0][EW-1:0]   mv;
        logic [2*NE-1:0][EW-1:0] cat;
        logic [NE-1:0][EW-1:0]   trn1, trn2, uzp1, uzp2, zip1, zip2, zip2n;
        logic [NE-1:0][EW-1:0]   sel;

        assign nv  = {item.first_high, item.first_low};
        assign mv  = {item.second_high, item.second_low};
        // narrow mode packs m directly above n
        assign cat = item.full_width
                   ? {item.second_high, item.second_low, item.first_high, item.first_low}
                   : {{svpu_pkg::VecW{1'b0}}, item.second_low, item.first_low};

        always_comb
        begin
            trn1  = '0;
            trn2  = '0;
            uzp1  = '0;
            uzp2  = '0;
            zip1  = '0;
            zip2  = '0;
            zip2n = '0;
            for (int p = 0; p < HE; p++)
            begin
                trn1[2*p]   = nv[2*p];
                trn1[2*p+1] = mv[2*p];
                trn2[2*p]   = nv[2*p+1];
                trn2[2*p+1] = mv[2*p+1];
                zip1[2*p]   = nv[p];
                zip1[2*p+1] = mv[p];
                zip2[2*p]   = nv[HE+p];
                zip2[2*p+1] = mv[HE+p];
            end
            // upper pairs of a 64-bit vector
            for (int p = 0; p < QE; p++)
            begin
                zip2n[2*p]   = nv[QE+p];
                zip2n[2*p+1] = mv[QE+p];
            end
            for (int e = 0; e < NE; e++)
            begin
                uzp1[e] = cat[2*e];
                uzp2[e] = cat[2*e+1];
            end
        end

        always_comb
        begin
            unique case (item.opcode)
                svpu_pkg::OP_TRN1: sel = trn1;
                svpu_pkg::OP_TRN2: sel = trn2;
                svpu_pkg::OP_UZP1: sel = uzp1;
                svpu_pkg::OP_UZP2: sel = uzp2;
                svpu_pkg::OP_ZIP1: sel = zip1;
                svpu_pkg::OP_ZIP2: sel = item.full_width ? zip2 : zip2n;
                default:           sel = '0;
            endcase
        end

        assign by_size[g] = sel;
    end

    logic                      reserved;
    logic [svpu_pkg::VecW-1:0] dest;

    assign reserved = !item.full_width && (item.elem_size == svpu_pkg::SIZE_64);

    always_comb
    begin
        unique case (item.elem_size)
            svpu_pkg::SIZE_8:  dest = by_size[0];
            svpu_pkg::SIZE_16: dest = by_size[1];
            svpu_pkg::SIZE_32: dest = by_size[2];
            svpu_pkg::SIZE_64: dest = by_size[3];
            default:           dest = '0;
        endcase
    end

    always_comb
    begin
        result.reserved_encoding = reserved;
        result.result_low        = reserved ? '0 : dest[svpu_pkg::HalfW-1:0];
        result.result_high       = (reserved || !item.full_width)
                                 ? '0 : dest[svpu_pkg::VecW-1:svpu_pkg::HalfW];
    end

endmodule

/* rtl/core/simd_vector_permute_unit_top.sv */
// Top level of the vector permute unit: input register, permute network, result register.
// Depends on svpu_pkg and svpu_permute.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall | opcode, full_width, elem_size, first_*, second_*
//  out     | output    | out_valid/out_stall | reserved_encoding, result_low, result_high
//
// One transaction per cycle sustained while out_stall is low; each transaction is held in
// the input register and then in the result register; out_valid rises when it moves into
// the result register, and the result leaves while out_stall is low.
// rst_n clears both valid bits asynchronously; payload registers are not reset.
// out_stall holds the result register; the input register keeps accepting while the
// result register can drain or is empty, so in_stall rises only when both are full.
module simd_vector_permute_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic        full_width,
    input  logic [1:0]  elem_size,
    input  logic [63:0] first_low,
    input  logic [63:0] first_high,
    input  logic [63:0] second_low,
    input  logic [63:0] second_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reserved_encoding,
    output logic [63:0] result_low,
    output logic [63:0] result_high
);

    logic                   s1_valid_reg, s1_valid_next;
    svpu_pkg::perm_item_t   s1_item_reg;
    logic                   s2_valid_reg, s2_valid_next;
    svpu_pkg::perm_result_t s2_result_reg;
    svpu_pkg::perm_result_t perm_out;
    logic                   in_take;
    logic                   s2_load;
    logic                   out_take;

    assign out_take = s2_valid_reg && !out_stall;
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    svpu_permute u_permute (
        .item   (s1_item_reg),
        .result (perm_out)
    );

    always_comb
    begin
        priority if (in_take)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        priority if (s2_load)
            s2_valid_next = 1'b1;
        else if (out_take)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.opcode      <= opcode;
            s1_item_reg.full_width  <= full_width;
            s1_item_reg.elem_size   <= elem_size;
            s1_item_reg.first_low   <= first_low;
            s1_item_reg.first_high  <= first_high;
            s1_item_reg.second_low  <= second_low;
            s1_item_reg.second_high <= second_high;
        end
        // advance only when the result register is free or draining
        if (s2_load)
        begin
            s2_result_reg <= perm_out;
        end
    end

    assign out_valid         = s2_valid_reg;
    assign reserved_encoding = s2_result_reg.reserved_encoding;
    assign result_low        = s2_result_reg.result_low;
    assign result_high       = s2_result_reg.result_high;

endmodule
